/* hw/rtl/pru_pkg.sv */
`timescale 1ns / 1ps

package pru_pkg;

  // default limits for the top-level parameters
  localparam int DEF_MAX_WIDTH = 1024;
  localparam int DEF_MAX_SCALE = 16;

  // configuration port
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 11;
  localparam int SCALE_REG_W = 5;
  localparam int WIDTH_REG_W = 11;

  localparam logic [CFG_IDX_W-1:0] REG_SCALE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH = 1'b1;

  // command codes
  localparam logic CMD_PUSH   = 1'b0;
  localparam logic CMD_REPLAY = 1'b1;

  // front-to-back queue
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  typedef struct packed {
    logic       command;
    logic [7:0] blue_in;
    logic [7:0] green_in;
    logic [7:0] red_in;
  } in_item_t;

  typedef struct packed {
    logic [7:0] blue_out;
    logic [7:0] green_out;
    logic [7:0] red_out;
    logic       row_end;
    logic [1:0] pad_bytes;
    logic       last;
  } out_item_t;

  // one classified item: pixel to repeat, row marker and row padding
  typedef struct packed {
    pixel_t     pixel;
    logic       row_end;
    logic [1:0] pad;
  } desc_t;

endpackage

/* hw/rtl/pru_front.sv */
`timescale 1ns / 1ps

module pru_front #(
  parameter int MAX_WIDTH = pru_pkg::DEF_MAX_WIDTH,
  parameter int MAX_SCALE = pru_pkg::DEF_MAX_SCALE
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_push,
  output logic                                   in_full,
  input  pru_pkg::in_item_t                      in_data,
  input  logic [$clog2(MAX_SCALE + 1)-1:0]       eff_s,
  input  logic [$clog2(MAX_WIDTH + 1)-1:0]       eff_w,
  input  logic [1:0]                             row_pad,
  input  logic                                   q_full,
  output logic                                   q_push,
  output pru_pkg::desc_t                         q_desc
);
  import pru_pkg::*;

  localparam int SCL_W  = $clog2(MAX_SCALE + 1);
  localparam int WEFF_W = $clog2(MAX_WIDTH + 1);
  localparam int COL_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int RL_W   = (MAX_SCALE > 1) ? $clog2(MAX_SCALE) : 1;
  localparam int CMP_W  = ((COL_W > WEFF_W) ? COL_W : WEFF_W) + 1;

  logic [COL_W-1:0] push_col_r;
  logic [COL_W-1:0] replay_col_r;
  logic [RL_W-1:0]  rl_r;
  logic             b_valid_r;
  logic             b_replay_r;
  logic             b_row_end_r;
  pixel_t           b_pix_r;
  pixel_t           rd_pix_r;
  pixel_t           line_mem [MAX_WIDTH];

  logic             accept;
  logic             is_replay;
  logic             push_end;
  logic             rep_end;
  logic             wr_en;
  logic             rd_en;
  logic             b_load;
  logic [COL_W-1:0] wlast;
  logic [COL_W-1:0] push_at;
  logic [COL_W-1:0] replay_at;
  pixel_t           in_pix;

  assign in_full   = b_valid_r && q_full;
  assign q_push    = b_valid_r && !q_full;
  assign accept    = in_push && !in_full;
  assign is_replay = (in_data.command == CMD_REPLAY);

  assign in_pix.red   = in_data.red_in;
  assign in_pix.green = in_data.green_in;
  assign in_pix.blue  = in_data.blue_in;

  // column past the current width clamps to the last column and ends the row
  assign wlast     = COL_W'(eff_w - WEFF_W'(1));
  assign push_end  = (CMP_W'(push_col_r) + CMP_W'(1)) >= CMP_W'(eff_w);
  assign rep_end   = (CMP_W'(replay_col_r) + CMP_W'(1)) >= CMP_W'(eff_w);
  assign push_at   = (CMP_W'(push_col_r) >= CMP_W'(eff_w)) ? wlast : push_col_r;
  assign replay_at = (CMP_W'(replay_col_r) >= CMP_W'(eff_w)) ? wlast : replay_col_r;

  // replay with no armed row is swallowed
  assign wr_en  = accept && !is_replay;
  assign rd_en  = accept && is_replay && (rl_r != '0);
  assign b_load = wr_en || rd_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      push_col_r   <= '0;
      replay_col_r <= '0;
      rl_r         <= '0;
      b_valid_r    <= 1'b0;
    end else begin
      b_valid_r <= b_load || (b_valid_r && q_full);
      if (wr_en) begin
        if (push_end) begin
          push_col_r   <= '0;
          replay_col_r <= '0;
          rl_r         <= RL_W'(eff_s - SCL_W'(1));
        end else begin
          push_col_r <= push_col_r + COL_W'(1);
        end
      end
      if (rd_en) begin
        if (rep_end) begin
          replay_col_r <= '0;
          rl_r         <= rl_r - RL_W'(1);
        end else begin
          replay_col_r <= replay_col_r + COL_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (b_load) begin
      b_replay_r  <= is_replay;
      b_pix_r     <= in_pix;
      b_row_end_r <= is_replay ? rep_end : push_end;
    end
  end

  // line buffer: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      line_mem[push_at] <= in_pix;
    end
    if (rd_en) begin
      rd_pix_r <= line_mem[replay_at];
    end
  end

  assign q_desc.pixel   = b_replay_r ? rd_pix_r : b_pix_r;
  assign q_desc.row_end = b_row_end_r;
  assign q_desc.pad     = b_row_end_r ? row_pad : 2'b00;

endmodule

/* hw/rtl/pru_queue.sv */
`timescale 1ns / 1ps

module pru_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_push,
  input  pru_pkg::desc_t q_desc,
  output logic           q_full,
  input  logic           q_pop,
  output logic           q_empty,
  output pru_pkg::desc_t q_head
);
  import pru_pkg::*;

  desc_t             slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;

  assign q_full  = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign q_empty = (cnt_r == '0);
  assign q_head  = slots[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (q_push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (q_pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      if (q_push && !q_pop) begin
        cnt_r <= cnt_r + QCNT_W'(1);
      end else if (q_pop && !q_push) begin
        cnt_r <= cnt_r - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_push) begin
      slots[wr_ptr_r] <= q_desc;
    end
  end

endmodule

/* hw/rtl/pru_back.sv */
`timescale 1ns / 1ps

module pru_back #(
  parameter int MAX_SCALE = pru_pkg::DEF_MAX_SCALE
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic [$clog2(MAX_SCALE + 1)-1:0] eff_s,
  input  logic                             q_empty,
  input  pru_pkg::desc_t                   q_head,
  output logic                             q_pop,
  output logic                             out_empty,
  input  logic                             out_pop,
  output pru_pkg::out_item_t               out_data
);
  import pru_pkg::*;

  localparam int SCL_W = $clog2(MAX_SCALE + 1);

  logic             act_valid_r;
  logic [SCL_W-1:0] act_rem_r;
  desc_t            act_desc_r;
  logic             out_valid_r;
  out_item_t        out_r;

  logic             slot_free;
  logic             emit;
  logic             final_copy;
  logic [SCL_W-1:0] src_cnt;
  desc_t            src;

  // the item in progress has priority; otherwise the queue head starts directly
  assign src        = act_valid_r ? act_desc_r : q_head;
  assign src_cnt    = act_valid_r ? act_rem_r : eff_s;
  assign final_copy = (src_cnt == SCL_W'(1));
  assign slot_free  = !out_valid_r || out_pop;
  assign emit       = slot_free && (act_valid_r || !q_empty);
  assign q_pop      = emit && !act_valid_r;

  assign out_empty = !out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= emit || (out_valid_r && !out_pop);
      if (emit) begin
        if (act_valid_r) begin
          if (final_copy) begin
            act_valid_r <= 1'b0;
          end
        end else if (!final_copy) begin
          act_valid_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      act_rem_r <= src_cnt - SCL_W'(1);
      if (!act_valid_r) begin
        act_desc_r <= q_head;
      end
      out_r.blue_out  <= src.pixel.blue;
      out_r.green_out <= src.pixel.green;
      out_r.red_out   <= src.pixel.red;
      out_r.row_end   <= final_copy && src.row_end;
      out_r.pad_bytes <= final_copy ? src.pad : 2'b00;
      out_r.last      <= final_copy;
    end
  end

endmodule

/* hw/rtl/pixel_replicate_upscaler.sv */
// Integer nearest-neighbor upscaler for rows of 24-bit pixels. A push item
// writes its pixel into the line buffer and yields it s times (s is the
// scale factor, clamped to 1..MAX_SCALE); when it completes an input row the
// row is armed for s-1 replays. A replay item reads the next buffered pixel
// and yields it s times; a replay with nothing armed is taken and yields
// nothing. The final pixel of each output row carries row_end and the count
// of zero pad bytes that bring the row to a multiple of 4 bytes; the last
// result of every item carries last. Throughput: one result per clock while
// out_pop keeps the single output register drained; each item yields s results.
// Input transfers go back to back while the four-entry queue between the
// classifying front end and the replicating back end has room. A push passes
// the front register, a queue slot and the output register on its way out, a
// replay likewise (buffer read is registered). The line buffer is not cleared
// at reset; replaying columns never written is undefined. Write configuration
// only while the block is idle.
`timescale 1ns / 1ps

module pixel_replicate_upscaler #(
  parameter int MAX_WIDTH = pru_pkg::DEF_MAX_WIDTH,
  parameter int MAX_SCALE = pru_pkg::DEF_MAX_SCALE
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_push,
  output logic                             in_full,
  input  pru_pkg::in_item_t                in_data,
  output logic                             out_empty,
  input  logic                             out_pop,
  output pru_pkg::out_item_t               out_data,
  input  logic                             cfg_we,
  input  logic [pru_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pru_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import pru_pkg::*;

  localparam int SCL_W  = $clog2(MAX_SCALE + 1);
  localparam int WEFF_W = $clog2(MAX_WIDTH + 1);

  // configuration registers, raw as written
  logic [SCALE_REG_W-1:0] scale_r;
  logic [WIDTH_REG_W-1:0] width_r;

  // effective scale and width after clamping
  logic [SCL_W-1:0]  eff_s;
  logic [WEFF_W-1:0] eff_w;
  logic [1:0]        row_pad;

  // front to queue, queue to back
  logic  q_push;
  logic  q_full;
  logic  q_pop;
  logic  q_empty;
  desc_t q_desc;
  desc_t q_head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= SCALE_REG_W'(1);
      width_r <= WIDTH_REG_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SCALE: scale_r <= cfg_data[SCALE_REG_W-1:0];
        REG_WIDTH: width_r <= cfg_data[WIDTH_REG_W-1:0];
        default: ;
      endcase
    end
  end

  // zero acts as one, anything above the limit acts as the limit
  always_comb begin
    if (scale_r == '0) begin
      eff_s = SCL_W'(1);
    end else if (int'(scale_r) > MAX_SCALE) begin
      eff_s = SCL_W'(MAX_SCALE);
    end else begin
      eff_s = SCL_W'(scale_r);
    end
    if (width_r == '0) begin
      eff_w = WEFF_W'(1);
    end else if (int'(width_r) > MAX_WIDTH) begin
      eff_w = WEFF_W'(MAX_WIDTH);
    end else begin
      eff_w = WEFF_W'(width_r);
    end
  end

  // output row is w*s pixels of 3 bytes; pad = (w*s) mod 4 only needs low bits
  assign row_pad = 2'(2'(eff_w) * 2'(eff_s));

  pru_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_SCALE (MAX_SCALE)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_full (in_full),
    .in_data (in_data),
    .eff_s   (eff_s),
    .eff_w   (eff_w),
    .row_pad (row_pad),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_desc  (q_desc)
  );

  pru_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_push  (q_push),
    .q_desc  (q_desc),
    .q_full  (q_full),
    .q_pop   (q_pop),
    .q_empty (q_empty),
    .q_head  (q_head)
  );

  pru_back #(
    .MAX_SCALE (MAX_SCALE)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .eff_s     (eff_s),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

endmodule
